>>> design/cbjm_pkg.sv
// ----------------------------------------------------------------------------
// cbjm_pkg
// Types, constants and register map shared by the CAN joint mailbox files.
// ----------------------------------------------------------------------------
package cbjm_pkg;

  // Joint store geometry and limits
  localparam int unsigned JOINT_SLOTS   = 16;
  localparam int unsigned JOINT_IDX_W   = 4;
  localparam int unsigned CARD_IDX_W    = 3;
  localparam int unsigned MAX_CARDS_DEF = 8;
  localparam int unsigned MAX_CARDS_LIM = 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned JCOUNT_W   = 5;
  localparam int unsigned TYPE_W     = 4;

  localparam logic [2:0] REG_CARD_TABLE  = 3'd0;
  localparam logic [2:0] REG_JOINT_COUNT = 3'd1;
  localparam logic [2:0] REG_TYPE_POS    = 3'd2;
  localparam logic [2:0] REG_TYPE_VEL    = 3'd3;
  localparam logic [2:0] REG_TYPE_FLT    = 3'd4;
  localparam logic [2:0] REG_TYPE_CUR    = 3'd5;

  localparam logic [TYPE_W-1:0] TYPE_POS_RST = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_VEL_RST = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_FLT_RST = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_CUR_RST = 4'd4;

  // CAN identifier fields
  localparam logic [10:0] ID_CLASS_MASK  = 11'h700;
  localparam logic [10:0] ID_CLASS_BCAST = 11'h100;
  localparam logic [10:0] ID_SRC_MASK    = 11'h0f0;
  localparam logic [10:0] ID_TYPE_MASK   = 11'h00f;

  // Item mode
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_READ_OK  = 2'd2,
    ST_READ_OOR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_POS = 2'd0,
    KIND_VEL = 2'd1,
    KIND_FLT = 2'd2,
    KIND_CUR = 2'd3
  } kind_t;

  // Write control from the frame decode to the joint store
  typedef struct packed {
    logic                  en;
    kind_t                 kind;
    logic [CARD_IDX_W-1:0] card;
    logic                  second;
  } store_wr_t;

  // One joint's stored values
  typedef struct packed {
    logic [31:0] position;
    logic [15:0] velocity;
    logic [15:0] acceleration;
    logic [15:0] fault_word;
    logic [15:0] motor_current;
    logic [15:0] control_value;
  } joint_rec_t;

endpackage

>>> design/can_broadcast_joint_mailbox_top.sv
// ----------------------------------------------------------------------------
// can_broadcast_joint_mailbox_top
// Stores two-joint CAN broadcast values per card and serves joint reads.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake               Word
// -------  ---------  ----------------------  --------------------------------
// in_      input      in_valid / in_stall     mode, frame_id, no_data, data,
//                                             joint_index
// out_     output     out_valid / out_stall   status and six joint values
// cfg_     input      APB write/read          card table, joint count, types
//
// Flow: a taken word is latched in the input register, decoded and applied
// to the joint store as it advances into the result register, and its result
// then shows on out_. One word per cycle is sustained while out_stall stays
// low; the single decode stage between input and result register sets that figure.
// Reset: rst_n is synchronous; it empties both registers, clears all joint
// values to zero and loads the type registers with 1, 2, 3 and 4.
// Stalls: in_stall rises only while the input register holds a word and the
// result register is full and stalled; otherwise a new word is taken while
// a finished result still waits.
//
module can_broadcast_joint_mailbox_top #(
  parameter int unsigned MAX_CARDS = cbjm_pkg::MAX_CARDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic [10:0]                         in_frame_id,
  input  logic                                in_frame_no_data,
  input  logic [63:0]                         in_frame_data,
  input  logic [cbjm_pkg::JOINT_IDX_W-1:0]    in_joint_index,

  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [31:0]                  out_position,
  output logic signed [15:0]                  out_velocity,
  output logic signed [15:0]                  out_acceleration,
  output logic signed [15:0]                  out_fault_word,
  output logic signed [15:0]                  out_motor_current,
  output logic signed [15:0]                  out_control_value,

  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cbjm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cbjm_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cbjm_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0]                       card_table_r;
  logic [cbjm_pkg::JCOUNT_W-1:0]     joint_count_r;
  logic [cbjm_pkg::TYPE_W-1:0]       type_pos_r;
  logic [cbjm_pkg::TYPE_W-1:0]       type_vel_r;
  logic [cbjm_pkg::TYPE_W-1:0]       type_flt_r;
  logic [cbjm_pkg::TYPE_W-1:0]       type_cur_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // registers sit on 8-byte strides
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_table_r  <= '0;
      joint_count_r <= '0;
      type_pos_r    <= cbjm_pkg::TYPE_POS_RST;
      type_vel_r    <= cbjm_pkg::TYPE_VEL_RST;
      type_flt_r    <= cbjm_pkg::TYPE_FLT_RST;
      type_cur_r    <= cbjm_pkg::TYPE_CUR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cbjm_pkg::REG_CARD_TABLE:  card_table_r  <= cfg_pwdata;
        cbjm_pkg::REG_JOINT_COUNT: joint_count_r <= cfg_pwdata[cbjm_pkg::JCOUNT_W-1:0];
        cbjm_pkg::REG_TYPE_POS:    type_pos_r    <= cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
        cbjm_pkg::REG_TYPE_VEL:    type_vel_r    <= cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
        cbjm_pkg::REG_TYPE_FLT:    type_flt_r    <= cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
        cbjm_pkg::REG_TYPE_CUR:    type_cur_r    <= cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
        default: begin
          // addresses beyond the map: drop the write
        end
      endcase
    end
  end

  // Read back: zero-extend the narrow registers
  always_comb begin
    case (cfg_idx)
      cbjm_pkg::REG_CARD_TABLE:  cfg_prdata = card_table_r;
      cbjm_pkg::REG_JOINT_COUNT: cfg_prdata = {59'd0, joint_count_r};
      cbjm_pkg::REG_TYPE_POS:    cfg_prdata = {60'd0, type_pos_r};
      cbjm_pkg::REG_TYPE_VEL:    cfg_prdata = {60'd0, type_vel_r};
      cbjm_pkg::REG_TYPE_FLT:    cfg_prdata = {60'd0, type_flt_r};
      cbjm_pkg::REG_TYPE_CUR:    cfg_prdata = {60'd0, type_cur_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: input register and result register
  // --------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_take;
  logic s1_adv;

  // advance the input register whenever the result register can take a word
  assign s1_adv   = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload register: hold while the word waits
  logic                              mode_r;
  logic [10:0]                       frame_id_r;
  logic                              no_data_r;
  logic [63:0]                       frame_data_r;
  logic [cbjm_pkg::JOINT_IDX_W-1:0]  joint_idx_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r       <= in_mode;
      frame_id_r   <= in_frame_id;
      no_data_r    <= in_frame_no_data;
      frame_data_r <= in_frame_data;
      joint_idx_r  <= in_joint_index;
    end
  end

  // --------------------------------------------------------------------------
  // Frame decode
  // --------------------------------------------------------------------------
  logic [3:0]                        src_nib;
  logic [3:0]                        type_nib;
  logic                              class_ok;
  logic                              card_hit;
  logic [cbjm_pkg::CARD_IDX_W-1:0]   card_sel;
  logic                              kind_hit;
  cbjm_pkg::kind_t                   kind_sel;
  logic [cbjm_pkg::JCOUNT_W-1:0]     second_joint;
  logic                              frame_ok;
  cbjm_pkg::store_wr_t               store_wr;

  assign class_ok = ((frame_id_r & cbjm_pkg::ID_CLASS_MASK) == cbjm_pkg::ID_CLASS_BCAST);
  assign src_nib  = frame_id_r[7:4];
  assign type_nib = frame_id_r[3:0];

  // Card lookup: scan from the top so the lowest matching card wins.
  // An address byte above 15 never equals a zero-extended nibble.
  always_comb begin
    card_hit = 1'b0;
    card_sel = '0;
    for (int k = MAX_CARDS - 1; k >= 0; k--) begin
      if (card_table_r[8*k +: 8] == {4'd0, src_nib}) begin
        card_hit = 1'b1;
        card_sel = k[cbjm_pkg::CARD_IDX_W-1:0];
      end
    end
  end

  // Type lookup in priority order position, velocity, fault, current
  always_comb begin
    kind_hit = 1'b1;
    kind_sel = cbjm_pkg::KIND_POS;
    if (type_nib == type_pos_r) begin
      kind_sel = cbjm_pkg::KIND_POS;
    end else if (type_nib == type_vel_r) begin
      kind_sel = cbjm_pkg::KIND_VEL;
    end else if (type_nib == type_flt_r) begin
      kind_sel = cbjm_pkg::KIND_FLT;
    end else if (type_nib == type_cur_r) begin
      kind_sel = cbjm_pkg::KIND_CUR;
    end else begin
      kind_hit = 1'b0;
    end
  end

  assign second_joint = {1'b0, card_sel, 1'b1};
  assign frame_ok     = ~no_data_r & class_ok & card_hit & kind_hit;

  assign store_wr.en     = s1_adv & (mode_r == cbjm_pkg::MODE_FRAME) & frame_ok;
  assign store_wr.kind   = kind_sel;
  assign store_wr.card   = card_sel;
  assign store_wr.second = (second_joint < joint_count_r);

  // --------------------------------------------------------------------------
  // Joint store
  // --------------------------------------------------------------------------
  cbjm_pkg::joint_rec_t rd_rec;

  cbjm_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (store_wr),
    .wr_data (frame_data_r),
    .rd_idx  (joint_idx_r),
    .rd_rec  (rd_rec)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  cbjm_pkg::status_t    status_nxt;
  cbjm_pkg::joint_rec_t rec_nxt;
  cbjm_pkg::status_t    status_r;
  cbjm_pkg::joint_rec_t rec_r;
  logic                 read_in_range;

  assign read_in_range = ({1'b0, joint_idx_r} < joint_count_r);

  always_comb begin
    rec_nxt = '0;
    if (mode_r == cbjm_pkg::MODE_FRAME) begin
      status_nxt = frame_ok ? cbjm_pkg::ST_STORED : cbjm_pkg::ST_IGNORED;
    end else if (read_in_range) begin
      status_nxt = cbjm_pkg::ST_READ_OK;
      rec_nxt    = rd_rec;
    end else begin
      status_nxt = cbjm_pkg::ST_READ_OOR;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status_r <= status_nxt;
      rec_r    <= rec_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_position      = rec_r.position;
  assign out_velocity      = rec_r.velocity;
  assign out_acceleration  = rec_r.acceleration;
  assign out_fault_word    = rec_r.fault_word;
  assign out_motor_current = rec_r.motor_current;
  assign out_control_value = rec_r.control_value;

`ifndef SYNTHESIS
  // an empty result register never stalls the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty result register");

  // a word that advances appears as a result in the next cycle
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word did not reach the result register");

  // the store is written only for frames that are reported stored
  a_write_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.en |=> (status_r == cbjm_pkg::ST_STORED))
    else $error("store written for a word not reported stored");

  // value fields are zero unless a read succeeded
  a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != cbjm_pkg::ST_READ_OK)) |-> (rec_r == '0))
    else $error("nonzero values on a non-read result");

  // a joint count write lands in the register
  a_jcount_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_idx == cbjm_pkg::REG_JOINT_COUNT))
      |=> (joint_count_r == $past(cfg_pwdata[cbjm_pkg::JCOUNT_W-1:0])))
    else $error("joint count write lost");
`endif

endmodule

>>> design/cbjm_store.sv
// ----------------------------------------------------------------------------
// cbjm_store
// Per-joint value store: two-joint frame writes, one-joint read.
// ----------------------------------------------------------------------------
module cbjm_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cbjm_pkg::store_wr_t                  wr,
  input  logic [63:0]                          wr_data,
  input  logic [cbjm_pkg::JOINT_IDX_W-1:0]     rd_idx,
  output cbjm_pkg::joint_rec_t                 rd_rec
);

  logic [31:0] pos_r [cbjm_pkg::JOINT_SLOTS];
  logic [15:0] vel_r [cbjm_pkg::JOINT_SLOTS];
  logic [15:0] acc_r [cbjm_pkg::JOINT_SLOTS];
  logic [15:0] flt_r [cbjm_pkg::JOINT_SLOTS];
  logic [15:0] cur_r [cbjm_pkg::JOINT_SLOTS];
  logic [15:0] ctl_r [cbjm_pkg::JOINT_SLOTS];

  logic [cbjm_pkg::JOINT_IDX_W-1:0] j_first;
  logic [cbjm_pkg::JOINT_IDX_W-1:0] j_second;

  // card k owns joints 2k and 2k+1
  assign j_first  = {wr.card, 1'b0};
  assign j_second = {wr.card, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cbjm_pkg::JOINT_SLOTS; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        acc_r[i] <= '0;
        flt_r[i] <= '0;
        cur_r[i] <= '0;
        ctl_r[i] <= '0;
      end
    end else if (wr.en) begin
      case (wr.kind)
        cbjm_pkg::KIND_POS: begin
          pos_r[j_first] <= wr_data[31:0];
          if (wr.second) begin
            pos_r[j_second] <= wr_data[63:32];
          end
        end
        cbjm_pkg::KIND_VEL: begin
          vel_r[j_first] <= wr_data[15:0];
          acc_r[j_first] <= wr_data[47:32];
          if (wr.second) begin
            vel_r[j_second] <= wr_data[31:16];
            acc_r[j_second] <= wr_data[63:48];
          end
        end
        cbjm_pkg::KIND_FLT: begin
          flt_r[j_first] <= wr_data[15:0];
          if (wr.second) begin
            flt_r[j_second] <= wr_data[31:16];
          end
        end
        cbjm_pkg::KIND_CUR: begin
          cur_r[j_first] <= wr_data[15:0];
          ctl_r[j_first] <= wr_data[47:32];
          if (wr.second) begin
            cur_r[j_second] <= wr_data[31:16];
            ctl_r[j_second] <= wr_data[63:48];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rd_rec.position      = pos_r[rd_idx];
  assign rd_rec.velocity      = vel_r[rd_idx];
  assign rd_rec.acceleration  = acc_r[rd_idx];
  assign rd_rec.fault_word    = flt_r[rd_idx];
  assign rd_rec.motor_current = cur_r[rd_idx];
  assign rd_rec.control_value = ctl_r[rd_idx];

endmodule

>>> test/mailbox_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mailbox_checker
// Predicts every result of the joint mailbox and compares it with the DUT.
// It watches the word channels and the register writes, keeps its own copy
// of the joint store, and hands back a mismatch count and a pending count.
// ----------------------------------------------------------------------------
module mailbox_checker #(
  parameter int unsigned NUM_CARDS = cbjm_pkg::MAX_CARDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_mode,
  input  logic [10:0]                     in_frame_id,
  input  logic                            in_frame_no_data,
  input  logic [63:0]                     in_frame_data,
  input  logic [3:0]                      in_joint_index,

  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_status,
  input  logic [31:0]                     out_position,
  input  logic [15:0]                     out_velocity,
  input  logic [15:0]                     out_acceleration,
  input  logic [15:0]                     out_fault_word,
  input  logic [15:0]                     out_motor_current,
  input  logic [15:0]                     out_control_value,

  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cbjm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cbjm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,

  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    cbjm_pkg::status_t    status;
    cbjm_pkg::joint_rec_t rec;
  } reply_t;

  logic [63:0]          card_table;
  logic [4:0]           joint_cnt;
  logic [3:0]           type_pos, type_vel, type_flt, type_cur;
  cbjm_pkg::joint_rec_t joint_mem [cbjm_pkg::JOINT_SLOTS];

  reply_t      reply_q [$];
  reply_t      want;
  int          mismatches = 0;

  // Apply one word to the joint store copy and return the reply it causes.
  function automatic reply_t mailbox_reply(input logic mode, input logic [10:0] id,
                                           input logic nd, input logic [63:0] data,
                                           input logic [3:0] idx);
    reply_t     r;
    int         card;
    logic [3:0] j, jn, src, kind;
    logic       second;
    r = '0;
    if (mode == cbjm_pkg::MODE_READ) begin
      if ({1'b0, idx} >= joint_cnt) begin
        r.status = cbjm_pkg::ST_READ_OOR;
      end else begin
        r.status = cbjm_pkg::ST_READ_OK;
        r.rec    = joint_mem[idx];
      end
      return r;
    end
    r.status = cbjm_pkg::ST_IGNORED;
    if (nd || ((id & cbjm_pkg::ID_CLASS_MASK) != cbjm_pkg::ID_CLASS_BCAST))
      return r;
    src  = id[7:4];
    kind = id[3:0];
    // lowest numbered card wins, bytes above 15 never match
    card = -1;
    for (int k = NUM_CARDS - 1; k >= 0; k--)
      if (card_table[8*k +: 8] == {4'h0, src})
        card = k;
    if (card < 0)
      return r;
    j      = 4'(card * 2);
    jn     = j + 4'd1;
    second = (int'(j) + 1) < int'(joint_cnt);
    r.status = cbjm_pkg::ST_STORED;
    if (kind == type_pos) begin
      joint_mem[j].position = data[31:0];
      if (second) joint_mem[jn].position = data[63:32];
    end else if (kind == type_vel) begin
      joint_mem[j].velocity     = data[15:0];
      joint_mem[j].acceleration = data[47:32];
      if (second) begin
        joint_mem[jn].velocity     = data[31:16];
        joint_mem[jn].acceleration = data[63:48];
      end
    end else if (kind == type_flt) begin
      joint_mem[j].fault_word = data[15:0];
      if (second) joint_mem[jn].fault_word = data[31:16];
    end else if (kind == type_cur) begin
      joint_mem[j].motor_current = data[15:0];
      joint_mem[j].control_value = data[47:32];
      if (second) begin
        joint_mem[jn].motor_current = data[31:16];
        joint_mem[jn].control_value = data[63:48];
      end
    end else begin
      r.status = cbjm_pkg::ST_IGNORED;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      card_table = '0;
      joint_cnt  = '0;
      type_pos   = cbjm_pkg::TYPE_POS_RST;
      type_vel   = cbjm_pkg::TYPE_VEL_RST;
      type_flt   = cbjm_pkg::TYPE_FLT_RST;
      type_cur   = cbjm_pkg::TYPE_CUR_RST;
      for (int s = 0; s < cbjm_pkg::JOINT_SLOTS; s++)
        joint_mem[s] = '0;
      reply_q.delete();
    end else begin
      // results first: a word taken at this edge cannot answer at this edge
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = reply_q.pop_front();
          compare_field("status",        32'(want.status),            32'(out_status));
          compare_field("position",      want.rec.position,           out_position);
          compare_field("velocity",      32'(want.rec.velocity),      32'(out_velocity));
          compare_field("acceleration",  32'(want.rec.acceleration),
                        32'(out_acceleration));
          compare_field("fault_word",    32'(want.rec.fault_word),    32'(out_fault_word));
          compare_field("motor_current", 32'(want.rec.motor_current),
                        32'(out_motor_current));
          compare_field("control_value", 32'(want.rec.control_value),
                        32'(out_control_value));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[cbjm_pkg::CFG_ADDR_W-1:3])
          cbjm_pkg::REG_CARD_TABLE:  card_table = cfg_pwdata;
          cbjm_pkg::REG_JOINT_COUNT: joint_cnt  = cfg_pwdata[cbjm_pkg::JCOUNT_W-1:0];
          cbjm_pkg::REG_TYPE_POS:    type_pos   = cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
          cbjm_pkg::REG_TYPE_VEL:    type_vel   = cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
          cbjm_pkg::REG_TYPE_FLT:    type_flt   = cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
          cbjm_pkg::REG_TYPE_CUR:    type_cur   = cfg_pwdata[cbjm_pkg::TYPE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        reply_q.push_back(mailbox_reply(in_mode, in_frame_id, in_frame_no_data,
                                        in_frame_data, in_joint_index));
    end
    fail_count <= mismatches;
    pending    <= reply_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames, joint reads and register writes into the joint mailbox.
// A directed run covers the frame kinds and the skip cases, then random
// runs under several register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;

  // Receiver pacing regimes for out_stall
  typedef enum logic [1:0] {
    RX_FREE   = 2'd0,
    RX_LIGHT  = 2'd1,
    RX_HEAVY  = 2'd2,
    RX_TOGGLE = 2'd3
  } rx_pace_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;

  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  in_mode          = cbjm_pkg::MODE_FRAME;
  logic [10:0]           in_frame_id      = '0;
  logic                  in_frame_no_data = 1'b0;
  logic [63:0]           in_frame_data    = '0;
  logic [3:0]            in_joint_index   = '0;

  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  logic [1:0]            out_status;
  logic signed [31:0]    out_position;
  logic signed [15:0]    out_velocity;
  logic signed [15:0]    out_acceleration;
  logic signed [15:0]    out_fault_word;
  logic signed [15:0]    out_motor_current;
  logic signed [15:0]    out_control_value;

  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [cbjm_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [cbjm_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [cbjm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int                    fail_count;
  int                    pending;

  // Stimulus-side copy of the settings, used only to aim frames at real cards
  logic [63:0]           cur_table;
  logic [3:0]            cur_types [4];
  int                    burst_left;

  rx_pace_t              rx_pace    = RX_FREE;
  int                    rx_left    = 0;

  always #5 clk = ~clk;

  can_broadcast_joint_mailbox_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_frame_id       (in_frame_id),
    .in_frame_no_data  (in_frame_no_data),
    .in_frame_data     (in_frame_data),
    .in_joint_index    (in_joint_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_position      (out_position),
    .out_velocity      (out_velocity),
    .out_acceleration  (out_acceleration),
    .out_fault_word    (out_fault_word),
    .out_motor_current (out_motor_current),
    .out_control_value (out_control_value),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  mailbox_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_frame_id       (in_frame_id),
    .in_frame_no_data  (in_frame_no_data),
    .in_frame_data     (in_frame_data),
    .in_joint_index    (in_joint_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_position      (out_position),
    .out_velocity      (out_velocity),
    .out_acceleration  (out_acceleration),
    .out_fault_word    (out_fault_word),
    .out_motor_current (out_motor_current),
    .out_control_value (out_control_value),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_pready        (cfg_pready),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Receiver: switch at random between free running, light, heavy and toggling
  // stall so stalls land on every phase of the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_pace   <= RX_FREE;
      rx_left   <= 50;
    end else begin
      if (rx_left == 0) begin
        rx_pace <= rx_pace_t'(2'($urandom_range(0, 3)));
        rx_left <= $urandom_range(10, 150);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_pace)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  // Hold one word on the input channel until it is taken, then either keep
  // valid up for the next word of the burst or drop it and idle a while.
  // Valid only drops with an idle gap behind it.
  task automatic push_word(input logic mode, input logic [10:0] id, input logic nd,
                           input logic [63:0] data, input logic [3:0] idx,
                           input bit last);
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_frame_id      <= id;
    in_frame_no_data <= nd;
    in_frame_data    <= data;
    in_joint_index   <= idx;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0 || last)
      in_valid <= 1'b0;
    if (burst_left <= 0 && !last) begin
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 6))
        @(posedge clk);
      // one burst in five runs long with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Frames carry a random joint index, reads a random id and payload, so the
  // unused fields still toggle.
  task automatic frame(input logic [10:0] id, input logic nd, input logic [63:0] data,
                       input bit last);
    push_word(cbjm_pkg::MODE_FRAME, id, nd, data, 4'($urandom_range(0, 15)), last);
  endtask

  task automatic read_joint(input logic [3:0] idx, input bit last);
    push_word(cbjm_pkg::MODE_READ, 11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
              {$urandom, $urandom}, idx, last);
  endtask

  // Mostly well-formed broadcasts aimed at a configured card and type, plus
  // reads, flagged frames and raw noise.
  task automatic rand_item(input bit last);
    logic [10:0] id;
    logic [63:0] d;
    int          k;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       d = '1;
      1:       d = '0;
      2:       d = 64'h8000_7fff_8000_7fff;
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      read_joint(4'($urandom_range(0, 15)), last);
    end else if ($urandom_range(0, 4) != 0) begin
      k  = $urandom_range(0, 7);
      id = {3'b001, cur_table[8*k +: 4], cur_types[$urandom_range(0, 3)]};
      if ($urandom_range(0, 6) == 0)
        id[3:0] = 4'($urandom_range(0, 15));
      frame(id, ($urandom_range(0, 19) == 0), d, last);
    end else begin
      frame(11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)), d, last);
    end
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      rand_item(i == n - 1);
  endtask

  // Wait until every expected result is back, then let the pipe settle.
  task automatic drain(input int tail);
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Write all six registers back to back; psel stays high between writes.
  task automatic set_config(input logic [63:0] tbl_v, input logic [4:0] count_v,
                            input logic [3:0] tp, input logic [3:0] tv,
                            input logic [3:0] tf, input logic [3:0] tc);
    logic [63:0] vals [6];
    logic [2:0]  regs [6];
    vals = '{tbl_v, 64'(count_v), 64'(tp), 64'(tv), 64'(tf), 64'(tc)};
    regs = '{cbjm_pkg::REG_CARD_TABLE, cbjm_pkg::REG_JOINT_COUNT, cbjm_pkg::REG_TYPE_POS,
             cbjm_pkg::REG_TYPE_VEL, cbjm_pkg::REG_TYPE_FLT, cbjm_pkg::REG_TYPE_CUR};
    for (int r = 0; r < 6; r++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {regs[r], 3'b000};
      cfg_pwdata  <= vals[r];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_table    = tbl_v;
    cur_types    = '{tp, tv, tf, tc};
  endtask

  // Card addresses that are all valid source nibbles; repeats happen now and then
  function automatic logic [63:0] rand_nibble_table();
    logic [63:0] t;
    for (int k = 0; k < 8; k++)
      t[8*k +: 8] = {4'h0, 4'($urandom_range(0, 15))};
    return t;
  endfunction

  initial begin
    cur_table  = '0;
    cur_types  = '{cbjm_pkg::TYPE_POS_RST, cbjm_pkg::TYPE_VEL_RST,
                   cbjm_pkg::TYPE_FLT_RST, cbjm_pkg::TYPE_CUR_RST};
    burst_left = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every card sits at address 0, joint count 0
    run_random(40);
    drain(4);

    // Directed: card 0 holds 0x25 (never a source), card 1 holds 5, cards 2
    // and 3 share 0xA, card 7 sits at 15; joint count 15 leaves out joint 15.
    set_config(64'h0f0c_0300_0a0a_0525, 5'd15,
               cbjm_pkg::TYPE_POS_RST, cbjm_pkg::TYPE_VEL_RST,
               cbjm_pkg::TYPE_FLT_RST, cbjm_pkg::TYPE_CUR_RST);
    frame(11'h151, 1'b0, '1, 1'b0);                        // position, joints 2 and 3
    read_joint(4'd2, 1'b0);
    read_joint(4'd3, 1'b0);
    frame(11'h1f2, 1'b0, 64'h8000_7fff_0001_fffe, 1'b0);   // top card, second joint skipped
    read_joint(4'd14, 1'b0);
    read_joint(4'd15, 1'b0);                               // read beyond joint count
    frame(11'h1a3, 1'b0, 64'h1234_5678_8000_7fff, 1'b0);   // shared address: card 2 wins
    read_joint(4'd4, 1'b0);
    read_joint(4'd5, 1'b0);
    read_joint(4'd6, 1'b0);
    frame(11'h104, 1'b0, 64'hfedc_ba98_7654_3210, 1'b0);   // current and control, card 4
    read_joint(4'd8, 1'b0);
    read_joint(4'd9, 1'b0);
    frame(11'h151, 1'b1, '0, 1'b0);                        // no-data flag: skip
    read_joint(4'd2, 1'b0);
    frame(11'h751, 1'b0, '0, 1'b0);                        // wrong class
    frame(11'h051, 1'b0, '0, 1'b0);
    frame(11'h121, 1'b0, '0, 1'b0);                        // no card at this source
    frame(11'h15f, 1'b0, '0, 1'b0);                        // unknown type nibble
    frame(11'h131, 1'b0, 64'h0000_0001_ffff_ffff, 1'b0);   // position, card 5
    read_joint(4'd11, 1'b0);
    read_joint(4'd0, 1'b1);
    drain(4);

    // Random phases over a spread of settings, extremes among them
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(rand_nibble_table(), 5'd16,
                      cbjm_pkg::TYPE_POS_RST, cbjm_pkg::TYPE_VEL_RST,
                      cbjm_pkg::TYPE_FLT_RST, cbjm_pkg::TYPE_CUR_RST);
        1: set_config({$urandom, $urandom}, 5'd0, 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
        2: begin
          // all type registers equal: position takes every match
          cur_types[0] = 4'($urandom_range(0, 15));
          set_config(rand_nibble_table(), 5'd31, cur_types[0], cur_types[0],
                     cur_types[0], cur_types[0]);
        end
        3: set_config(64'h0eff_ffff_ffff_ffff, 5'd1, 4'd15, 4'd0, 4'd15, 4'd0);
        4: set_config(64'h0, 5'($urandom_range(2, 16)),
                      cbjm_pkg::TYPE_CUR_RST, cbjm_pkg::TYPE_FLT_RST,
                      cbjm_pkg::TYPE_VEL_RST, cbjm_pkg::TYPE_POS_RST);
        default: set_config(rand_nibble_table(), 5'($urandom_range(0, 16)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      run_random(110);
      drain(4);
    end

    drain(8);
    if (fail_count == 0 && pending == 0) begin
      $display("can_broadcast_joint_mailbox_top test passed");
    end else begin
      $display("can_broadcast_joint_mailbox_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("can_broadcast_joint_mailbox_top test failed");
    $finish;
  end

endmodule

>>> sim.f
design/cbjm_pkg.sv
design/cbjm_store.sv
design/can_broadcast_joint_mailbox_top.sv
test/mailbox_checker.sv
test/tb_top.sv
